// ===== src/ajb_pkg.sv =====
// ----------------------------------------------------------------------------
// ajb_pkg: shared definitions for the audio jitter buffer.
// Field widths, register defaults, event and action codes, and the
// per-transaction result record passed from the controller to the top level.
// ----------------------------------------------------------------------------
package ajb_pkg;

  localparam int RING_DEPTH_DEF = 16384;
  localparam int FRAME_LEN_DEF  = 320;

  localparam int SMP_W = 16;
  localparam int LVL_W = 14;

  localparam logic [LVL_W-1:0] TARGET_RST = LVL_W'(960);
  localparam logic [LVL_W-1:0] HIGH_RST   = LVL_W'(2240);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_PLAY = 1'b1;

  localparam logic CFG_TARGET = 1'b0;
  localparam logic CFG_HIGH   = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_DROP,
    EV_UNDERRUN,
    EV_DISCARD
  } event_t;

  typedef struct packed {
    logic             from_ring;
    logic             frame_start;
    event_t           event_res;
    logic [LVL_W-1:0] fill_level;
  } result_t;

endpackage

// ===== src/ajb_ring.sv =====
// ----------------------------------------------------------------------------
// ajb_ring: sample ring storage.
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ajb_ring
  import ajb_pkg::*;
#(
  parameter int DEPTH = RING_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [SMP_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [SMP_W-1:0] rdata
);

  logic [SMP_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ajb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ajb_ctrl: push and playout control for the jitter buffer.
// Tracks frame positions, ring slots and the published level, decides
// frame admission, drops and underruns, and issues ring accesses.
// ----------------------------------------------------------------------------
module ajb_ctrl
  import ajb_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int FRAME_LEN  = FRAME_LEN_DEF,
  parameter int AW         = $clog2(RING_DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             action,
  input  logic [SMP_W-1:0] sample_in,
  input  logic [LVL_W-1:0] target_level,
  input  logic [LVL_W-1:0] high_level,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [SMP_W-1:0] mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  output result_t          res
);

  localparam int PW = $clog2(FRAME_LEN);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X   = (AW+1)'(RING_DEPTH);
  localparam logic [AW:0]   FL_X      = (AW+1)'(FRAME_LEN);
  localparam logic [PW-1:0] POS_LAST  = PW'(FRAME_LEN - 1);

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
    return (a == LAST_SLOT) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_add_frame(input logic [AW-1:0] a);
    logic [AW:0] s;
    s = {1'b0, a} + FL_X;
    return (s >= DEPTH_X) ? AW'(s - DEPTH_X) : AW'(s);
  endfunction

  logic [AW-1:0] wr_slot, wr_slot_next;
  logic [AW-1:0] wa, wa_next;
  logic [AW-1:0] rd_slot, rd_slot_next;
  logic [AW-1:0] level, level_next;
  logic [PW-1:0] push_pos, push_pos_next;
  logic [PW-1:0] play_pos, play_pos_next;
  logic          push_acc, push_acc_next;
  logic          prebuf, prebuf_next;
  logic          has_audio, has_audio_next;

  logic          acc;
  logic [AW-1:0] addr;
  logic [AW:0]   lvl;
  logic          pre;
  logic          audio;
  logic [AW-1:0] rs;

  always_comb begin
    wr_slot_next   = wr_slot;
    wa_next        = wa;
    rd_slot_next   = rd_slot;
    level_next     = level;
    push_pos_next  = push_pos;
    play_pos_next  = play_pos;
    push_acc_next  = push_acc;
    prebuf_next    = prebuf;
    has_audio_next = has_audio;
    mem_we         = 1'b0;
    mem_waddr      = wa;
    mem_wdata      = sample_in;
    mem_re         = 1'b0;
    mem_raddr      = rd_slot;
    res            = '0;
    res.event_res  = EV_NONE;
    acc            = push_acc;
    addr           = wa;
    lvl            = {1'b0, level};
    pre            = prebuf;
    audio          = has_audio;
    rs             = rd_slot;

    if (action == ACT_PUSH) begin
      if (push_pos == '0) begin
        res.frame_start = 1'b1;
        acc  = (lvl + FL_X) <= (DEPTH_X - (AW+1)'(1));
        addr = wr_slot;
        if (!acc) begin
          res.event_res = EV_DISCARD;
        end
      end
      mem_we    = step && acc;
      mem_waddr = addr;
      wa_next   = slot_inc(addr);
      if (push_pos == POS_LAST) begin
        push_pos_next = '0;
        push_acc_next = 1'b0;
        if (acc) begin
          wr_slot_next = slot_inc(addr);
          level_next   = AW'(lvl + FL_X);
        end
      end else begin
        push_pos_next = push_pos + PW'(1);
        push_acc_next = acc;
      end
    end else begin
      if (play_pos == '0) begin
        res.frame_start = 1'b1;
        audio = 1'b0;
        if (pre && (32'(lvl) >= 32'(target_level))) begin
          pre = 1'b0;
        end
        if (!pre) begin
          if ((32'(lvl) >= 32'(high_level)) && (lvl >= FL_X)) begin
            rs            = slot_add_frame(rs);
            lvl           = lvl - FL_X;
            res.event_res = EV_DROP;
          end
          if (lvl >= FL_X) begin
            audio = 1'b1;
          end else begin
            res.event_res = EV_UNDERRUN;
            pre           = 1'b1;
          end
        end
      end
      if (audio) begin
        mem_re        = step;
        mem_raddr     = rs;
        res.from_ring = 1'b1;
        rs            = slot_inc(rs);
        lvl           = lvl - (AW+1)'(1);
      end
      if (play_pos == POS_LAST) begin
        play_pos_next  = '0;
        has_audio_next = 1'b0;
      end else begin
        play_pos_next  = play_pos + PW'(1);
        has_audio_next = audio;
      end
      rd_slot_next = rs;
      level_next   = AW'(lvl);
      prebuf_next  = pre;
    end
    res.fill_level = LVL_W'(level_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_slot   <= '0;
      wa        <= '0;
      rd_slot   <= '0;
      level     <= '0;
      push_pos  <= '0;
      play_pos  <= '0;
      push_acc  <= 1'b0;
      prebuf    <= 1'b1;
      has_audio <= 1'b0;
    end else if (step) begin
      wr_slot   <= wr_slot_next;
      wa        <= wa_next;
      rd_slot   <= rd_slot_next;
      level     <= level_next;
      push_pos  <= push_pos_next;
      play_pos  <= play_pos_next;
      push_acc  <= push_acc_next;
      prebuf    <= prebuf_next;
      has_audio <= has_audio_next;
    end
  end

endmodule

// ===== src/audio_jitter_buffer.sv =====
// ----------------------------------------------------------------------------
// audio_jitter_buffer: frame-granular PCM jitter buffer.
// The block takes one transaction per clock and returns its result in the next
// cycle from an output register; input ready is high whenever that register
// is empty or being drained in the same cycle. All samples live in a single
// ring memory with one write port and one registered read port, so a push
// writes and a play reads in the cycle of acceptance. There is no clearing
// pass after reset: unpublished entries are never read.
// ----------------------------------------------------------------------------
module audio_jitter_buffer
  import ajb_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int FRAME_LEN  = FRAME_LEN_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [LVL_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    action,
  input  logic signed [SMP_W-1:0] sample_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] sample_out,
  output logic                    from_ring,
  output logic                    frame_start,
  output logic [1:0]              event_res,
  output logic [LVL_W-1:0]        fill_level
);

  localparam int AW = $clog2(RING_DEPTH);

  logic [LVL_W-1:0] target_level;
  logic [LVL_W-1:0] high_level;
  logic             step;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [SMP_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [SMP_W-1:0] rd_data;
  result_t          res;
  result_t          res_q;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign step      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= TARGET_RST;
      high_level   <= HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET: target_level <= cfg_data;
        CFG_HIGH:   high_level   <= cfg_data;
        default:    ;
      endcase
    end
  end

  ajb_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .FRAME_LEN  (FRAME_LEN),
    .AW         (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .action       (action),
    .sample_in    (sample_in),
    .target_level (target_level),
    .high_level   (high_level),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .res          (res)
  );

  ajb_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
      res_q     <= res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sample_out  = res_q.from_ring ? rd_data : '0;
  assign from_ring   = res_q.from_ring;
  assign frame_start = res_q.frame_start;
  assign event_res   = res_q.event_res;
  assign fill_level  = res_q.fill_level;

  a_event_on_frame_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res != EV_NONE) |-> frame_start)
    else $error("Event reported outside a frame start.");

  a_no_audio_on_underrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && from_ring |-> (event_res != EV_UNDERRUN) && (event_res != EV_DISCARD))
    else $error("Ring sample delivered together with an underrun or discard.");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("Result appeared without an accepted transaction.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("Input stalled while the output register is empty.");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the audio jitter buffer.
// Push and playout transactions go in through a queue-fed driver. A monitor
// predicts every result with a cycle-free model of the frame ring and checks
// each returned result field by field. Phases vary the watermark registers
// and the idle and stall patterns on both channels. The first phase publishes
// a frame of corner and random samples, which is played back from the ring,
// from the first phase on, while the next frame is pushed.
// ----------------------------------------------------------------------------
module tb_top;
  import ajb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PTR_SPAN    = 2 * RING_DEPTH_DEF;
  localparam logic [LVL_W-1:0] LVL_MAX = '1;

  typedef struct packed {
    logic             act;
    logic [SMP_W-1:0] smp;
  } audio_req_t;

  typedef struct packed {
    logic [SMP_W-1:0] smp;
    logic             from_ring;
    logic             frame_start;
    event_t           ev;
    logic [LVL_W-1:0] level;
  } buffer_out_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_index = CFG_TARGET;
  logic [LVL_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    action = ACT_PUSH;
  logic signed [SMP_W-1:0] sample_in = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SMP_W-1:0] sample_out;
  logic                    from_ring;
  logic                    frame_start;
  logic [1:0]              event_res;
  logic [LVL_W-1:0]        fill_level;

  audio_req_t  req_queue[$];
  buffer_out_t expected_outputs[$];
  bit          in_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          fail_count = 0;
  int          cycle_count = 0;

  logic [SMP_W-1:0] ring_mem [RING_DEPTH_DEF];
  int unsigned      wr_ptr = 0;
  int unsigned      rd_ptr = 0;
  int unsigned      push_pos = 0;
  int unsigned      play_pos = 0;
  bit               push_ok = 1'b0;
  bit               prebuf = 1'b1;
  bit               has_audio = 1'b0;
  logic [LVL_W-1:0] target_lvl = TARGET_RST;
  logic [LVL_W-1:0] high_lvl = HIGH_RST;

  audio_jitter_buffer u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .from_ring  (from_ring),
    .frame_start(frame_start),
    .event_res  (event_res),
    .fill_level (fill_level)
  );

  always #4 clk = ~clk;

  function automatic int unsigned ring_level();
    return (wr_ptr + PTR_SPAN - rd_ptr) % PTR_SPAN;
  endfunction

  function automatic buffer_out_t step_buffer(logic act, logic [SMP_W-1:0] smp);
    buffer_out_t r;
    int unsigned lvl;
    r = '0;
    if (act == ACT_PUSH) begin
      if (push_pos == 0) begin
        lvl = ring_level();
        r.frame_start = 1'b1;
        push_ok = (RING_DEPTH_DEF - 1 - lvl) >= FRAME_LEN_DEF;
        if (!push_ok) r.ev = EV_DISCARD;
      end
      if (push_ok) ring_mem[(wr_ptr + push_pos) % RING_DEPTH_DEF] = smp;
      push_pos++;
      if (push_pos >= FRAME_LEN_DEF) begin
        push_pos = 0;
        if (push_ok) wr_ptr = (wr_ptr + FRAME_LEN_DEF) % PTR_SPAN;
        push_ok = 1'b0;
      end
    end else begin
      if (play_pos == 0) begin
        lvl = ring_level();
        r.frame_start = 1'b1;
        has_audio = 1'b0;
        if (prebuf && lvl >= target_lvl) prebuf = 1'b0;
        if (!prebuf) begin
          if (lvl >= high_lvl && lvl >= FRAME_LEN_DEF) begin
            rd_ptr = (rd_ptr + FRAME_LEN_DEF) % PTR_SPAN;
            lvl -= FRAME_LEN_DEF;
            r.ev = EV_DROP;
          end
          if (lvl >= FRAME_LEN_DEF) begin
            has_audio = 1'b1;
          end else begin
            r.ev = EV_UNDERRUN;
            prebuf = 1'b1;
          end
        end
      end
      if (has_audio) begin
        r.smp = ring_mem[rd_ptr % RING_DEPTH_DEF];
        r.from_ring = 1'b1;
        rd_ptr = (rd_ptr + 1) % PTR_SPAN;
      end
      play_pos++;
      if (play_pos >= FRAME_LEN_DEF) begin
        play_pos = 0;
        has_audio = 1'b0;
      end
    end
    r.level = LVL_W'(ring_level());
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic add_run(int n, int push_pct);
    audio_req_t r;
    repeat (n) begin
      r.act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_PLAY;
      r.smp = rand_sample();
      req_queue.push_back(r);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (req_queue.size() != 0 || in_valid || expected_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [LVL_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_TARGET) target_lvl = val;
    else high_lvl = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    audio_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (req_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = req_queue.pop_front();
        in_valid  <= 1'b1;
        action    <= nxt.act;
        sample_in <= nxt.smp;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    buffer_out_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        expected_outputs.push_back(step_buffer(action, sample_in));
      end
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result transaction with nothing expected");
        end else begin
          want = expected_outputs.pop_front();
          check_field("sample_out", $signed(want.smp), $signed(sample_out));
          check_field("from_ring", want.from_ring, from_ring);
          check_field("frame_start", want.frame_start, frame_start);
          check_field("event_res", want.ev, event_res);
          check_field("fill_level", want.level, fill_level);
        end
      end
    end
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    logic [SMP_W-1:0] corner [6];
    audio_req_t r;
    corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(CFG_TARGET, '0);
    write_reg(CFG_HIGH, LVL_MAX);
    foreach (corner[i]) begin
      r = '{ACT_PUSH, corner[i]};
      req_queue.push_back(r);
    end
    add_run(FRAME_LEN_DEF - 6, 100);
    add_run(110, 60);
    wait_drained();

    send_idle_pct = 66;
    recv_stall_pct = 0;
    write_reg(CFG_TARGET, TARGET_RST);
    write_reg(CFG_HIGH, HIGH_RST);
    add_run(140, 60);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 66;
    write_reg(CFG_TARGET, LVL_W'(FRAME_LEN_DEF));
    write_reg(CFG_HIGH, LVL_W'(1600));
    add_run(140, 60);
    wait_drained();

    send_idle_pct = 24;
    recv_stall_pct = 24;
    write_reg(CFG_TARGET, LVL_W'(640));
    write_reg(CFG_HIGH, LVL_MAX);
    add_run(140, 60);
    wait_drained();
    repeat (10) @(posedge clk);

    if (fail_count == 0 && expected_outputs.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
